FILE: hdl/i2c_master_transaction_sequencer_unit_macros.svh
// assertion macros for the i2c transaction sequencer
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication under active-low reset
`define I2CS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2cs same-cycle check failed");

// next-cycle implication under active-low reset
`define I2CS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2cs next-cycle check failed");

`endif

FILE: hdl/i2cs_pkg.sv
// shared codes and types of the i2c transaction sequencer
package i2cs_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_BEGIN  = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_SEND     = 3'd2;
    localparam logic [2:0] CMD_RECV_ACK = 3'd3;
    localparam logic [2:0] CMD_RECV_NAK = 3'd4;
    localparam logic [2:0] CMD_STOP     = 3'd5;

    localparam logic [3:0] RC_OK           = 4'd0;
    localparam logic [3:0] RC_RETRIES      = 4'd1;
    localparam logic [3:0] RC_PROBE_ARB_ST = 4'd2;
    localparam logic [3:0] RC_BAD_START    = 4'd3;
    localparam logic [3:0] RC_PROBE_NACK   = 4'd4;
    localparam logic [3:0] RC_PROBE_ARB_AD = 4'd5;
    localparam logic [3:0] RC_BAD_ADDR     = 4'd6;
    localparam logic [3:0] RC_READ_FAIL    = 4'd7;
    localparam logic [3:0] RC_BAD_LENGTH   = 4'd8;

    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RSTART    = 8'h10;
    localparam logic [7:0] ST_WADDR_ACK = 8'h18;
    localparam logic [7:0] ST_WADDR_NAK = 8'h20;
    localparam logic [7:0] ST_WDATA_ACK = 8'h28;
    localparam logic [7:0] ST_ARB_LOST  = 8'h38;
    localparam logic [7:0] ST_RADDR_ACK = 8'h40;
    localparam logic [7:0] ST_RADDR_NAK = 8'h48;
    localparam logic [7:0] ST_RDATA_ACK = 8'h50;
    localparam logic [7:0] ST_RDATA_NAK = 8'h58;
    localparam logic [7:0] ST_MASK      = 8'hF8;

    localparam logic [3:0] RETRY_RESET = 4'd3;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] send_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic [3:0] result_code;
    } t_result;

    typedef struct packed {
        logic valid;
        logic use_mem;
    } t_res_ctl;

    typedef struct packed {
        logic idle;
        logic load_full;
    } t_ctrl_status;

endpackage

FILE: hdl/i2cs_txbuf.sv
// transmit byte buffer, one write and one registered read port
module i2cs_txbuf #(
    parameter int TX_DEPTH = 16,
    parameter int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [TX_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/i2cs_ctrl.sv
// transaction state and next-command decision for each accepted item
module i2cs_ctrl #(
    parameter int TX_DEPTH = 16,
    parameter int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1,
    parameter int SW = $clog2(TX_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [3:0]            i_cfg_wdata,
    input  logic                  i_accept,
    input  logic [1:0]            i_op,
    input  logic [1:0]            i_kind,
    input  logic [6:0]            i_slave_address,
    input  logic [15:0]           i_length,
    input  logic                  i_keep_bus,
    input  logic [7:0]            i_tx_byte,
    input  logic [7:0]            i_bus_status,
    input  logic [7:0]            i_rx_data,
    output logic                  o_mem_we,
    output logic [AW-1:0]         o_mem_waddr,
    output logic [7:0]            o_mem_wdata,
    output logic                  o_mem_re,
    output logic [AW-1:0]         o_mem_raddr,
    output i2cs_pkg::t_res_ctl    o_res_ctl,
    output i2cs_pkg::t_result     o_res,
    output i2cs_pkg::t_ctrl_status o_status
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_ADDR,
        PH_WDATA,
        PH_RDATA
    } t_phase;

    localparam logic [SW-1:0] DEPTH_SW  = SW'(TX_DEPTH);
    localparam logic [16:0]   DEPTH_LEN = 17'(TX_DEPTH);

    t_phase        r_phase, n_phase;
    logic [1:0]    r_kind, n_kind;
    logic [6:0]    r_addr, n_addr;
    logic [15:0]   r_total, n_total;
    logic [15:0]   r_left, n_left;
    logic          r_hold, n_hold;
    logic [3:0]    r_attempts, n_attempts;
    logic [SW-1:0] r_load_ptr, n_load_ptr;
    logic [SW-1:0] r_send_idx, n_send_idx;
    logic [3:0]    r_retry_limit;

    logic [7:0] st;
    logic [3:0] lim;
    logic       fin, ret;
    logic [3:0] code;
    logic       rv;
    logic [7:0] rb;
    i2cs_pkg::t_result  res;
    i2cs_pkg::t_res_ctl ctl;

    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_addr     = r_addr;
        n_total    = r_total;
        n_left     = r_left;
        n_hold     = r_hold;
        n_attempts = r_attempts;
        n_load_ptr = r_load_ptr;
        n_send_idx = r_send_idx;
        res        = '0;
        ctl        = '0;
        fin        = 1'b0;
        ret        = 1'b0;
        code       = i2cs_pkg::RC_OK;
        rv         = 1'b0;
        rb         = 8'd0;
        o_mem_we   = 1'b0;
        o_mem_re   = 1'b0;
        st         = i_bus_status & i2cs_pkg::ST_MASK;
        lim        = (r_retry_limit == 4'd0) ? 4'd1 : r_retry_limit;

        if (i_accept) begin
            case (i_op)
                i2cs_pkg::OP_LOAD: begin
                    if (r_phase == PH_IDLE && r_load_ptr < DEPTH_SW) begin
                        o_mem_we   = 1'b1;
                        n_load_ptr = r_load_ptr + SW'(1);
                    end
                end
                i2cs_pkg::OP_BEGIN: begin
                    if (r_phase == PH_IDLE && i_kind != 2'd3) begin
                        n_kind     = i_kind;
                        n_addr     = i_slave_address;
                        n_total    = i_length;
                        n_left     = i_length;
                        n_hold     = i_keep_bus;
                        n_send_idx = '0;
                        ctl.valid  = 1'b1;
                        if (i_kind == i2cs_pkg::KIND_WRITE && {1'b0, i_length} > DEPTH_LEN) begin
                            n_load_ptr      = '0;
                            res.done_res    = 1'b1;
                            res.result_code = i2cs_pkg::RC_BAD_LENGTH;
                        end else begin
                            n_attempts  = 4'd1;
                            n_phase     = PH_START;
                            res.command = i2cs_pkg::CMD_START;
                        end
                    end
                end
                i2cs_pkg::OP_STATUS: begin
                    case (r_phase)
                        PH_START: begin
                            ctl.valid = 1'b1;
                            if (st == i2cs_pkg::ST_ARB_LOST) begin
                                if (r_kind == i2cs_pkg::KIND_PROBE) begin
                                    fin  = 1'b1;
                                    code = i2cs_pkg::RC_PROBE_ARB_ST;
                                end else begin
                                    ret  = 1'b1;
                                    code = i2cs_pkg::RC_RETRIES;
                                end
                            end else if (st != i2cs_pkg::ST_START && st != i2cs_pkg::ST_RSTART) begin
                                fin  = 1'b1;
                                code = i2cs_pkg::RC_BAD_START;
                            end else begin
                                n_phase       = PH_ADDR;
                                res.command   = i2cs_pkg::CMD_SEND;
                                res.send_byte = {r_addr, r_kind == i2cs_pkg::KIND_READ};
                            end
                        end
                        PH_ADDR: begin
                            ctl.valid = 1'b1;
                            if (r_kind == i2cs_pkg::KIND_PROBE) begin
                                fin = 1'b1;
                                if (st == i2cs_pkg::ST_WADDR_NAK) begin
                                    code = i2cs_pkg::RC_PROBE_NACK;
                                end else if (st == i2cs_pkg::ST_ARB_LOST) begin
                                    code = i2cs_pkg::RC_PROBE_ARB_AD;
                                end else if (st != i2cs_pkg::ST_WADDR_ACK) begin
                                    code = i2cs_pkg::RC_BAD_ADDR;
                                end
                            end else if (r_kind == i2cs_pkg::KIND_WRITE) begin
                                if (st == i2cs_pkg::ST_WADDR_NAK || st == i2cs_pkg::ST_ARB_LOST) begin
                                    ret  = 1'b1;
                                    code = i2cs_pkg::RC_RETRIES;
                                end else if (st != i2cs_pkg::ST_WADDR_ACK) begin
                                    fin  = 1'b1;
                                    code = i2cs_pkg::RC_BAD_ADDR;
                                end else if (r_left == 16'd0) begin
                                    fin = 1'b1;
                                end else begin
                                    n_phase     = PH_WDATA;
                                    res.command = i2cs_pkg::CMD_SEND;
                                    ctl.use_mem = 1'b1;
                                    o_mem_re    = 1'b1;
                                    n_send_idx  = r_send_idx + SW'(1);
                                end
                            end else begin
                                if (st == i2cs_pkg::ST_RADDR_NAK || st == i2cs_pkg::ST_ARB_LOST) begin
                                    ret  = 1'b1;
                                    code = i2cs_pkg::RC_RETRIES;
                                end else if (st != i2cs_pkg::ST_RADDR_ACK) begin
                                    fin  = 1'b1;
                                    code = i2cs_pkg::RC_BAD_ADDR;
                                end else if (r_left == 16'd0) begin
                                    fin = 1'b1;
                                end else begin
                                    n_phase     = PH_RDATA;
                                    res.command = (r_left > 16'd1) ? i2cs_pkg::CMD_RECV_ACK
                                                                   : i2cs_pkg::CMD_RECV_NAK;
                                end
                            end
                        end
                        PH_WDATA: begin
                            ctl.valid = 1'b1;
                            if (st != i2cs_pkg::ST_WDATA_ACK) begin
                                ret  = 1'b1;
                                code = i2cs_pkg::RC_RETRIES;
                            end else if (r_left <= 16'd1) begin
                                n_left = 16'd0;
                                fin    = 1'b1;
                            end else begin
                                n_left      = r_left - 16'd1;
                                res.command = i2cs_pkg::CMD_SEND;
                                ctl.use_mem = 1'b1;
                                o_mem_re    = 1'b1;
                                n_send_idx  = r_send_idx + SW'(1);
                            end
                        end
                        PH_RDATA: begin
                            ctl.valid = 1'b1;
                            if (st == i2cs_pkg::ST_RDATA_NAK) begin
                                fin = 1'b1;
                                rv  = 1'b1;
                                rb  = i_rx_data;
                            end else if (st != i2cs_pkg::ST_RDATA_ACK) begin
                                ret  = 1'b1;
                                code = i2cs_pkg::RC_READ_FAIL;
                            end else if (r_left <= 16'd1) begin
                                ret  = 1'b1;
                                code = i2cs_pkg::RC_READ_FAIL;
                                rv   = 1'b1;
                                rb   = i_rx_data;
                            end else begin
                                n_left       = r_left - 16'd1;
                                res.command  = (r_left > 16'd2) ? i2cs_pkg::CMD_RECV_ACK
                                                                : i2cs_pkg::CMD_RECV_NAK;
                                res.rx_valid = 1'b1;
                                res.rx_byte  = i_rx_data;
                            end
                        end
                        default: begin
                            ctl.valid = 1'b0;
                        end
                    endcase
                end
                default: begin
                    ctl.valid = 1'b0;
                end
            endcase

            if (ret) begin
                if (r_attempts < lim) begin
                    n_attempts   = r_attempts + 4'd1;
                    n_left       = r_total;
                    n_send_idx   = '0;
                    n_phase      = PH_START;
                    res.command  = i2cs_pkg::CMD_START;
                    res.rx_valid = rv;
                    res.rx_byte  = rb;
                end else begin
                    fin = 1'b1;
                end
            end
            if (fin) begin
                res.command     = (r_kind == i2cs_pkg::KIND_PROBE || !r_hold)
                                  ? i2cs_pkg::CMD_STOP : i2cs_pkg::CMD_NONE;
                res.send_byte   = 8'd0;
                res.rx_valid    = rv;
                res.rx_byte     = rb;
                res.done_res    = 1'b1;
                res.result_code = code;
                n_phase         = PH_IDLE;
                if (r_kind == i2cs_pkg::KIND_WRITE) begin
                    n_load_ptr = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_kind        <= '0;
            r_addr        <= '0;
            r_total       <= '0;
            r_left        <= '0;
            r_hold        <= 1'b0;
            r_attempts    <= '0;
            r_load_ptr    <= '0;
            r_send_idx    <= '0;
            r_retry_limit <= i2cs_pkg::RETRY_RESET;
        end else begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_addr     <= n_addr;
            r_total    <= n_total;
            r_left     <= n_left;
            r_hold     <= n_hold;
            r_attempts <= n_attempts;
            r_load_ptr <= n_load_ptr;
            r_send_idx <= n_send_idx;
            if (i_cfg_wen) begin
                r_retry_limit <= i_cfg_wdata;
            end
        end
    end

    assign o_mem_waddr        = r_load_ptr[AW-1:0];
    assign o_mem_wdata        = i_tx_byte;
    assign o_mem_raddr        = r_send_idx[AW-1:0];
    assign o_res              = res;
    assign o_res_ctl          = ctl;
    assign o_status.idle      = (r_phase == PH_IDLE);
    assign o_status.load_full = (r_load_ptr >= DEPTH_SW);

endmodule

FILE: hdl/i2c_master_transaction_sequencer_unit.sv
// i2c master transaction sequencer: top level with output register
// an accepted item's result is registered and shows on the master side in the next cycle
// throughput: one item per cycle unless the master side stalls the output register
// data bytes come from the transmit buffer through its registered read port
// reset: synchronous active low, idle phase, retry limit 3, buffer contents undefined
// the buffer needs no clearing pass, items are taken from the first cycle after reset
`include "i2c_master_transaction_sequencer_unit_macros.svh"

module i2c_master_transaction_sequencer_unit #(
    parameter int TX_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // kind, slave_address, length, keep_bus, tx_byte, bus_status, rx_data
    input  logic [55:0] i_s_axis_tdata,
    // op
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // command, send_byte, rx_valid, rx_byte, done_res, result_code
    output logic [31:0] o_m_axis_tdata
);

    localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int SW = $clog2(TX_DEPTH + 1);

    logic                   accept;
    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [7:0]             mem_wdata, mem_rdata;
    i2cs_pkg::t_res_ctl     res_ctl;
    i2cs_pkg::t_result      res;
    i2cs_pkg::t_ctrl_status ctrl_status;

    logic              r_out_valid;
    logic              r_use_mem;
    i2cs_pkg::t_result r_res;
    logic [7:0]        send_byte;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    i2cs_ctrl #(
        .TX_DEPTH (TX_DEPTH),
        .AW       (AW),
        .SW       (SW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (accept),
        .i_op            (i_s_axis_tuser),
        .i_kind          (i_s_axis_tdata[1:0]),
        .i_slave_address (i_s_axis_tdata[8:2]),
        .i_length        (i_s_axis_tdata[24:9]),
        .i_keep_bus      (i_s_axis_tdata[25]),
        .i_tx_byte       (i_s_axis_tdata[33:26]),
        .i_bus_status    (i_s_axis_tdata[41:34]),
        .i_rx_data       (i_s_axis_tdata[49:42]),
        .o_mem_we        (mem_we),
        .o_mem_waddr     (mem_waddr),
        .o_mem_wdata     (mem_wdata),
        .o_mem_re        (mem_re),
        .o_mem_raddr     (mem_raddr),
        .o_res_ctl       (res_ctl),
        .o_res           (res),
        .o_status        (ctrl_status)
    );

    i2cs_txbuf #(
        .TX_DEPTH (TX_DEPTH),
        .AW       (AW)
    ) u_txbuf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_use_mem   <= 1'b0;
        end else if (accept) begin
            r_out_valid <= res_ctl.valid;
            r_use_mem   <= res_ctl.use_mem;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    assign send_byte       = r_use_mem ? mem_rdata : r_res.send_byte;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_res.result_code, r_res.done_res, r_res.rx_byte,
                              r_res.rx_valid, send_byte, r_res.command};

    `I2CS_ASSERT_NXT(a_done_leaves_idle, i_clk, i_rst_n,
        accept && res_ctl.valid && res.done_res, ctrl_status.idle)
    `I2CS_ASSERT_NXT(a_start_leaves_busy, i_clk, i_rst_n,
        accept && res_ctl.valid && res.command == i2cs_pkg::CMD_START, !ctrl_status.idle)
    `I2CS_ASSERT_IMP(a_mem_only_on_send, i_clk, i_rst_n,
        r_out_valid && r_use_mem, r_res.command == i2cs_pkg::CMD_SEND && !r_res.done_res)
    `I2CS_ASSERT_IMP(a_no_load_when_full, i_clk, i_rst_n,
        ctrl_status.load_full, !mem_we)

endmodule
